@@ src/gssc_pkg.sv @@
// Shared constants, codes and types for the gas sensor sample conditioner.
package gssc_pkg;

  localparam int SAMPLE_W      = 12;
  localparam int SUM_W         = 15;
  localparam int LEVEL_W       = 10;
  localparam int WEIGHT_W      = 9;
  localparam int DISP_W        = 9;
  localparam int STATUS_W      = 4;
  localparam int HIT_W         = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 12;

  localparam int GROUP_SIZE    = 6;
  localparam int FAULT_CONFIRM = 8;
  localparam int SAMPLE_LIMIT  = 4092;
  localparam int LEVEL_MAX     = 999;
  localparam int DISPLAY_MAX   = 500;
  localparam int SCALE_GAIN    = 5000;
  localparam int WEIGHT_ONE    = 256;
  localparam int HIT_MAX       = 15;

  // Shared multiplier operand and product widths
  localparam int MUL_W         = 13;
  localparam int PROD_W        = 2 * MUL_W;

  // Divider: numerator up to 999*500 + 511, divisor is the level span
  localparam int NUM_W         = 19;
  localparam int DEN_W         = LEVEL_W;
  localparam int DIV_CNT_W     = $clog2(NUM_W);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_POINT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_THR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT     = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_FRESH          = 4'd0;
  localparam logic [STATUS_W-1:0] ST_HELD_OPEN      = 4'd1;
  localparam logic [STATUS_W-1:0] ST_HELD_SHORT     = 4'd2;
  localparam logic [STATUS_W-1:0] ST_OFF            = 4'd3;
  localparam logic [STATUS_W-1:0] ST_FEW_SAMPLES    = 4'd4;
  localparam logic [STATUS_W-1:0] ST_OPEN_NO_VALUE  = 4'd5;
  localparam logic [STATUS_W-1:0] ST_SHORT_NO_VALUE = 4'd6;
  localparam logic [STATUS_W-1:0] ST_OPEN_FAULT     = 4'd7;
  localparam logic [STATUS_W-1:0] ST_SHORT_FAULT    = 4'd8;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numerator;
    logic [DEN_W-1:0] denominator;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ src/gssc_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module gssc_divider
  import gssc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(NUM_W - 1);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] step;
  logic [NUM_W-1:0]     num;
  logic [DEN_W-1:0]     den;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       diff;
  logic                 fits;

  assign trial = {rem, num[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.numerator;
      den <= req.denominator;
      rem <= '0;
    end else if (busy) begin
      // shift the next numerator bit in, keep the difference when it fits
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num <= {num[NUM_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = num;

endmodule

@@ src/gas_sensor_sample_conditioner_core.sv @@
// Gas sensor sample conditioner: converter words arrive in groups of six and each group
// yields one result word, as does every sensor-off word. A word that neither closes a group
// nor reports sensor off keeps the input ready; a sensor-off word goes straight to the
// output step. A closing word runs a sequencer around one shared 13x13 multiplier
// (scaling, two filter products, display gain) and a 19-step restoring divider for the
// display mapping: a fresh value is scaled, filtered and mapped, a held value only mapped,
// and fault, pending with no value and short-group results go to the output step. The input
// is not ready while a group closes, and a finished result holds the block in its last step
// for as long as the output register is full; a result that has been handed on waits there
// while the next word is taken.
module gas_sensor_sample_conditioner_core
  import gssc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // [11:0] sample
  input  logic [1:0]            s_axis_tuser,  // [0] conversion_ok, [1] sensor_off
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,  // [8:0] display_value
  output logic [3:0]            m_axis_tuser,  // [3:0] status
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_EVAL      = 4'd1;
  localparam logic [3:0] S_SCALE_MUL = 4'd2;
  localparam logic [3:0] S_SCALE     = 4'd3;
  localparam logic [3:0] S_IIR_A     = 4'd4;
  localparam logic [3:0] S_IIR_B     = 4'd5;
  localparam logic [3:0] S_IIR_SUM   = 4'd6;
  localparam logic [3:0] S_MAP       = 4'd7;
  localparam logic [3:0] S_DIV_START = 4'd8;
  localparam logic [3:0] S_DIV_WAIT  = 4'd9;
  localparam logic [3:0] S_DONE      = 4'd10;

  // configuration
  logic [LEVEL_W-1:0]  zero_point;
  logic [LEVEL_W-1:0]  full_point;
  logic [SAMPLE_W-1:0] open_thr;
  logic [SAMPLE_W-1:0] short_thr;
  logic [WEIGHT_W-1:0] weight;

  // group and filter state
  logic [3:0]          state;
  logic [2:0]          group_pos;
  logic [2:0]          good_count;
  logic [SUM_W-1:0]    sample_sum;
  logic [SAMPLE_W-1:0] largest;
  logic [SAMPLE_W-1:0] smallest;
  logic [HIT_W-1:0]    open_hits;
  logic [HIT_W-1:0]    short_hits;
  logic [LEVEL_W-1:0]  filt;

  // datapath payload
  logic [SAMPLE_W-1:0] avg;
  logic [LEVEL_W-1:0]  level;
  logic [18:0]         acc;
  logic [PROD_W-1:0]   prod;
  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;
  logic [DISP_W-1:0]   res_disp;
  logic [STATUS_W-1:0] res_status;

  logic [SAMPLE_W-1:0] sample;
  logic                conv_ok;
  logic                sensor_off;
  logic                accept;
  logic                good;
  logic                group_end;
  logic [SUM_W-1:0]    trim;
  logic [SAMPLE_W-1:0] avg_now;
  logic [HIT_W-1:0]    open_inc;
  logic [HIT_W-1:0]    short_inc;
  logic [WEIGHT_W-1:0] w_eff;
  logic [WEIGHT_W-1:0] w_rest;
  logic [SAMPLE_W-1:0] scaled;
  logic [18:0]         iir_sum;
  logic [10:0]         iir_level;
  logic [LEVEL_W-1:0]  span;
  logic                out_free;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign sample     = s_axis_tdata[SAMPLE_W-1:0];
  assign conv_ok    = s_axis_tuser[0];
  assign sensor_off = s_axis_tuser[1];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign good          = conv_ok && (sample <= SAMPLE_W'(SAMPLE_LIMIT));
  assign group_end     = (group_pos == 3'(GROUP_SIZE - 1));

  assign trim      = sample_sum - SUM_W'(largest) - SUM_W'(smallest);
  assign avg_now   = trim[SAMPLE_W+1:2];
  assign open_inc  = (open_hits == HIT_W'(HIT_MAX)) ? open_hits : open_hits + 1'b1;
  assign short_inc = (short_hits == HIT_W'(HIT_MAX)) ? short_hits : short_hits + 1'b1;

  assign w_eff     = (weight > WEIGHT_W'(WEIGHT_ONE)) ? WEIGHT_W'(WEIGHT_ONE) : weight;
  assign w_rest    = WEIGHT_W'(WEIGHT_ONE) - w_eff;
  // floor(floor(avg*5000/4096)*5/10) is one shift of thirteen
  assign scaled    = prod[SAMPLE_W+12:13];
  assign iir_sum   = acc + prod[18:0];
  assign iir_level = iir_sum[18:8];
  assign span      = full_point - zero_point;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  // shared multiplier operand select
  always_comb begin
    mul_a = MUL_W'(avg);
    mul_b = MUL_W'(SCALE_GAIN);
    case (state)
      S_IIR_A: begin
        mul_a = MUL_W'(w_eff);
        mul_b = MUL_W'(level);
      end
      S_IIR_B: begin
        mul_a = MUL_W'(w_rest);
        mul_b = MUL_W'(filt);
      end
      S_MAP: begin
        mul_a = MUL_W'(filt - zero_point);
        mul_b = MUL_W'(DISPLAY_MAX);
      end
      default: begin
        mul_a = MUL_W'(avg);
        mul_b = MUL_W'(SCALE_GAIN);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign div_req.start       = (state == S_DIV_START);
  assign div_req.numerator   = prod[NUM_W-1:0] + NUM_W'(span >> 1);
  assign div_req.denominator = span;

  gssc_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_point <= '0;
      full_point <= LEVEL_W'(LEVEL_MAX);
      open_thr   <= SAMPLE_W'(40);
      short_thr  <= SAMPLE_W'(4050);
      weight     <= WEIGHT_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ZERO_POINT: zero_point <= cfg_data[LEVEL_W-1:0];
        REG_FULL_POINT: full_point <= cfg_data[LEVEL_W-1:0];
        REG_OPEN_THR:   open_thr   <= cfg_data;
        REG_SHORT_THR:  short_thr  <= cfg_data;
        REG_WEIGHT:     weight     <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      group_pos  <= '0;
      good_count <= '0;
      sample_sum <= '0;
      largest    <= '0;
      smallest   <= '1;
      open_hits  <= '0;
      short_hits <= '0;
      filt       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (sensor_off) begin
              group_pos  <= '0;
              good_count <= '0;
              sample_sum <= '0;
              largest    <= '0;
              smallest   <= '1;
              res_status <= ST_OFF;
              res_disp   <= '0;
              state      <= S_DONE;
            end else begin
              if (good) begin
                if (sample > largest) largest <= sample;
                if (sample < smallest) smallest <= sample;
                sample_sum <= sample_sum + SUM_W'(sample);
                good_count <= good_count + 1'b1;
              end
              group_pos <= group_pos + 1'b1;
              if (group_end) begin
                state <= S_EVAL;
              end
            end
          end
        end
        S_EVAL: begin
          // clear the group while its totals are read
          group_pos  <= '0;
          good_count <= '0;
          sample_sum <= '0;
          largest    <= '0;
          smallest   <= '1;
          avg        <= avg_now;
          res_disp   <= '0;
          if (good_count < 3'(GROUP_SIZE)) begin
            res_status <= ST_FEW_SAMPLES;
            state      <= S_DONE;
          end else if (avg_now <= open_thr) begin
            // open wins when both thresholds hit
            if (open_inc >= HIT_W'(FAULT_CONFIRM)) begin
              open_hits  <= '0;
              short_hits <= '0;
              filt       <= '0;
              res_status <= ST_OPEN_FAULT;
              state      <= S_DONE;
            end else begin
              open_hits <= open_inc;
              if (filt != '0) begin
                res_status <= ST_HELD_OPEN;
                state      <= S_MAP;
              end else begin
                res_status <= ST_OPEN_NO_VALUE;
                state      <= S_DONE;
              end
            end
          end else if (avg_now >= short_thr) begin
            if (short_inc >= HIT_W'(FAULT_CONFIRM)) begin
              open_hits  <= '0;
              short_hits <= '0;
              filt       <= '0;
              res_status <= ST_SHORT_FAULT;
              state      <= S_DONE;
            end else begin
              short_hits <= short_inc;
              if (filt != '0) begin
                res_status <= ST_HELD_SHORT;
                state      <= S_MAP;
              end else begin
                res_status <= ST_SHORT_NO_VALUE;
                state      <= S_DONE;
              end
            end
          end else begin
            open_hits  <= '0;
            short_hits <= '0;
            res_status <= ST_FRESH;
            state      <= S_SCALE_MUL;
          end
        end
        S_SCALE_MUL: begin
          state <= S_SCALE;
        end
        S_SCALE: begin
          if (filt == '0) begin
            // first value loads the filter directly
            filt  <= (scaled > SAMPLE_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : scaled[LEVEL_W-1:0];
            state <= S_MAP;
          end else begin
            level <= (scaled > SAMPLE_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : scaled[LEVEL_W-1:0];
            state <= S_IIR_A;
          end
        end
        S_IIR_A: begin
          state <= S_IIR_B;
        end
        S_IIR_B: begin
          acc   <= prod[18:0];
          state <= S_IIR_SUM;
        end
        S_IIR_SUM: begin
          filt  <= (iir_level > 11'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : iir_level[LEVEL_W-1:0];
          state <= S_MAP;
        end
        S_MAP: begin
          if (filt <= zero_point) begin
            res_disp <= '0;
            state    <= S_DONE;
          end else if (filt >= full_point) begin
            res_disp <= DISP_W'(DISPLAY_MAX);
            state    <= S_DONE;
          end else begin
            state <= S_DIV_START;
          end
        end
        S_DIV_START: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            res_disp <= div_rsp.quotient[DISP_W-1:0];
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_axis_tdata <= 16'(res_disp);
      m_axis_tuser <= res_status;
    end
  end

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for gas_sensor_sample_conditioner_core with a built-in predictor.
module tb;
  import gssc_pkg::*;

  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 3000;
  localparam int PRESSURE_SET  = 4;
  localparam int PRINT_CAP     = 40;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                ok;
    logic                off;
  } conv_word_t;

  typedef struct packed {
    logic [DISP_W-1:0]   display;
    logic [STATUS_W-1:0] status;
  } reading_t;

  typedef enum int {
    R_MID, R_LOW, R_HIGH, R_WIDE, R_FLAWED, R_ABORT, R_NOISE
  } regime_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;   // [11:0] sample
  logic [1:0]            s_axis_tuser = '0;   // [0] conversion_ok, [1] sensor_off
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;        // [8:0] display_value
  logic [3:0]            m_axis_tuser;        // [3:0] status
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gas_sensor_sample_conditioner_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor copy of the registers
  logic [LEVEL_W-1:0]  zero_pt   = 10'd0;
  logic [LEVEL_W-1:0]  full_pt   = 10'd999;
  logic [SAMPLE_W-1:0] open_thr  = 12'd40;
  logic [SAMPLE_W-1:0] short_thr = 12'd4050;
  logic [WEIGHT_W-1:0] weight    = 9'd64;

  // Predictor copy of the state
  logic [2:0]          grp_pos    = '0;
  logic [2:0]          good_cnt   = '0;
  logic [SUM_W-1:0]    acc_sum    = '0;
  logic [SAMPLE_W-1:0] peak       = '0;
  logic [SAMPLE_W-1:0] trough     = '1;
  logic [HIT_W-1:0]    open_hits  = '0;
  logic [HIT_W-1:0]    short_hits = '0;
  logic [LEVEL_W-1:0]  smoothed   = '0;

  conv_word_t words_pending[$];
  reading_t   readings_due[$];

  int send_idle_pct    = 0;
  int recv_stall_pct   = 0;
  int setting_no       = 0;
  int hold_left        = 0;
  bit hold_done        = 1'b0;
  int quiet_cycles     = 0;
  int words_sent       = 0;
  int readings_checked = 0;
  int mismatches       = 0;
  int status_seen[16];

  task automatic note_mismatch(input string what);
    if (mismatches < PRINT_CAP)
      $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic void clear_group();
    grp_pos  = '0;
    good_cnt = '0;
    acc_sum  = '0;
    peak     = '0;
    trough   = '1;
  endfunction

  function automatic logic [DISP_W-1:0] display_of(input logic [LEVEL_W-1:0] lvl);
    int unsigned span, above;
    if (lvl <= zero_pt) return '0;
    if (lvl >= full_pt) return DISP_W'(DISPLAY_MAX);
    span  = full_pt - zero_pt;
    above = lvl - zero_pt;
    return DISP_W'((above * DISPLAY_MAX + span / 2) / span);
  endfunction

  // A confirmed fault wipes both counters and the filter
  function automatic void resolve_hit(input logic [HIT_W-1:0] hits,
                                      input logic [STATUS_W-1:0] held,
                                      input logic [STATUS_W-1:0] no_value,
                                      input logic [STATUS_W-1:0] confirmed,
                                      output reading_t res);
    res = '0;
    if (hits >= FAULT_CONFIRM) begin
      open_hits  = '0;
      short_hits = '0;
      smoothed   = '0;
      res.status = confirmed;
    end else if (smoothed != 0) begin
      res.display = display_of(smoothed);
      res.status  = held;
    end else begin
      res.status = no_value;
    end
  endfunction

  function automatic void close_group(output reading_t res);
    int unsigned avg, lvl, w, blend;
    res = '0;
    if (good_cnt < GROUP_SIZE) begin
      res.status = ST_FEW_SAMPLES;
      return;
    end
    avg = (acc_sum - peak - trough) / 4;
    // open test first: it wins when both thresholds are hit
    if (avg <= open_thr) begin
      open_hits = (open_hits == HIT_MAX) ? open_hits : open_hits + 1'b1;
      resolve_hit(open_hits, ST_HELD_OPEN, ST_OPEN_NO_VALUE, ST_OPEN_FAULT, res);
      return;
    end
    if (avg >= short_thr) begin
      short_hits = (short_hits == HIT_MAX) ? short_hits : short_hits + 1'b1;
      resolve_hit(short_hits, ST_HELD_SHORT, ST_SHORT_NO_VALUE, ST_SHORT_FAULT, res);
      return;
    end
    open_hits  = '0;
    short_hits = '0;
    lvl = avg * SCALE_GAIN / 4096 * 5 / 10;
    if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
    if (smoothed == 0) begin
      blend = lvl;
    end else begin
      w     = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
      blend = (w * lvl + (WEIGHT_ONE - w) * smoothed) >> 8;
    end
    if (blend > LEVEL_MAX) blend = LEVEL_MAX;
    smoothed    = LEVEL_W'(blend);
    res.display = display_of(smoothed);
    res.status  = ST_FRESH;
  endfunction

  function automatic bit condition_word(input conv_word_t wd, output reading_t res);
    res = '0;
    if (wd.off) begin
      clear_group();
      res.status = ST_OFF;
      return 1'b1;
    end
    if (wd.ok && wd.sample <= SAMPLE_LIMIT) begin
      if (wd.sample > peak) peak = wd.sample;
      if (wd.sample < trough) trough = wd.sample;
      acc_sum  = acc_sum + wd.sample;
      good_cnt = good_cnt + 1'b1;
    end
    grp_pos = grp_pos + 1'b1;
    if (grp_pos < GROUP_SIZE) return 1'b0;
    close_group(res);
    clear_group();
    return 1'b1;
  endfunction

  // Driver: offer queued words, predict each one as it is taken
  always @(posedge clk) begin
    conv_word_t taken, nxt;
    reading_t   res;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        taken = '{sample: s_axis_tdata[SAMPLE_W-1:0], ok: s_axis_tuser[0],
                  off: s_axis_tuser[1]};
        if (condition_word(taken, res)) readings_due.push_back(res);
        words_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (words_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = words_pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, nxt.sample};
          s_axis_tuser  <= {nxt.off, nxt.ok};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once, so the block backs up onto its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (setting_no == PRESSURE_SET && !hold_done && s_axis_tvalid) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each reading against the oldest prediction
  always @(posedge clk) begin
    reading_t due;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (readings_due.size() == 0) begin
          note_mismatch($sformatf("unexpected reading status %0d display %0d",
                                  m_axis_tuser, m_axis_tdata));
        end else begin
          due = readings_due.pop_front();
          if (m_axis_tuser !== due.status)
            note_mismatch($sformatf("status got %0d want %0d", m_axis_tuser, due.status));
          if (m_axis_tdata !== {7'b0, due.display})
            note_mismatch($sformatf("display got 0x%h want %0d (status %0d)",
                                    m_axis_tdata, due.display, due.status));
          status_seen[due.status]++;
        end
        readings_checked++;
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("gas_sensor_sample_conditioner_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ZERO_POINT: zero_pt   = val[LEVEL_W-1:0];
      REG_FULL_POINT: full_pt   = val[LEVEL_W-1:0];
      REG_OPEN_THR:   open_thr  = val[SAMPLE_W-1:0];
      REG_SHORT_THR:  short_thr = val[SAMPLE_W-1:0];
      REG_WEIGHT:     weight    = val[WEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int unsigned zp, input int unsigned fp,
                               input int unsigned ot, input int unsigned st,
                               input int unsigned wt, input int snd, input int rcv);
    write_reg(REG_ZERO_POINT, zp);
    write_reg(REG_FULL_POINT, fp);
    write_reg(REG_OPEN_THR, ot);
    write_reg(REG_SHORT_THR, st);
    write_reg(REG_WEIGHT, wt);
    send_idle_pct  = snd;
    recv_stall_pct = rcv;
    setting_no++;
  endtask

  task automatic queue_word(input int unsigned smp, input bit ok, input bit off);
    words_pending.push_back('{sample: smp[SAMPLE_W-1:0], ok: ok, off: off});
  endtask

  task automatic queue_group(input regime_t rg);
    int unsigned centre, spread, lim, bad, n;
    centre = $urandom_range(300, 3800);
    spread = $urandom_range(0, 250);
    lim    = $urandom_range(0, 90);
    bad    = $urandom_range(0, 5);
    n      = $urandom_range(0, 5);
    case (rg)
      R_MID:  for (int i = 0; i < GROUP_SIZE; i++)
                queue_word(centre - spread + $urandom_range(0, 2 * spread), 1'b1, 1'b0);
      R_LOW:  for (int i = 0; i < GROUP_SIZE; i++)
                queue_word($urandom_range(0, lim), 1'b1, 1'b0);
      R_HIGH: for (int i = 0; i < GROUP_SIZE; i++)
                queue_word($urandom_range(4030, SAMPLE_LIMIT), 1'b1, 1'b0);
      R_WIDE: for (int i = 0; i < GROUP_SIZE; i++)
                queue_word($urandom_range(0, SAMPLE_LIMIT), 1'b1, 1'b0);
      R_FLAWED: begin
        for (int i = 0; i < GROUP_SIZE; i++) begin
          if (i != bad)
            queue_word($urandom_range(0, SAMPLE_LIMIT), 1'b1, 1'b0);
          else if ($urandom_range(1))
            queue_word($urandom_range(0, 4095), 1'b0, 1'b0);
          else
            queue_word($urandom_range(SAMPLE_LIMIT + 1, 4095), 1'b1, 1'b0);
        end
      end
      R_ABORT: begin
        for (int i = 0; i < n; i++) queue_word($urandom_range(0, SAMPLE_LIMIT), 1'b1, 1'b0);
        queue_word($urandom_range(0, 4095), 1'($urandom_range(1)), 1'b1);
      end
      default: begin
        // loose words knock the grouping out of step; realign half the time
        for (int i = 0; i <= n; i++)
          queue_word($urandom_range(0, 4095), 1'($urandom_range(1)),
                     $urandom_range(7) == 0);
        if ($urandom_range(1)) queue_word($urandom_range(0, 4095), 1'b1, 1'b1);
      end
    endcase
  endtask

  task automatic queue_random(input int quota);
    int      target, roll, burst;
    regime_t rg;
    target = words_pending.size() + quota;
    while (words_pending.size() < target) begin
      roll  = $urandom_range(99);
      burst = $urandom_range(1, 10);
      rg = (roll < 40) ? R_MID : (roll < 52) ? R_LOW : (roll < 64) ? R_HIGH :
           (roll < 74) ? R_WIDE : (roll < 84) ? R_FLAWED : (roll < 92) ? R_ABORT : R_NOISE;
      for (int g = 0; g < burst; g++) queue_group(rg);
    end
  endtask

  task automatic queue_directed();
    // clean group: fresh value loads the filter directly
    queue_word(0, 1'b1, 1'b0);
    queue_word(SAMPLE_LIMIT, 1'b1, 1'b0);
    for (int i = 0; i < 4; i++) queue_word(2000, 1'b1, 1'b0);
    // one timed-out conversion and one out-of-range sample
    queue_word(4095, 1'b0, 1'b0);
    queue_word(SAMPLE_LIMIT + 1, 1'b1, 1'b0);
    for (int i = 0; i < 4; i++) queue_word(1234, 1'b1, 1'b0);
    // sensor off part way through a group
    queue_word(1500, 1'b1, 1'b0);
    queue_word(2500, 1'b1, 1'b0);
    queue_word(4095, 1'b1, 1'b1);
    // open hit with a held value, then short hit with a held value
    for (int i = 0; i < GROUP_SIZE; i++) queue_word(0, 1'b1, 1'b0);
    for (int i = 0; i < GROUP_SIZE; i++) queue_word(SAMPLE_LIMIT, 1'b1, 1'b0);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (words_pending.size() != 0 || s_axis_tvalid || readings_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    queue_directed();
    queue_random(130);
    drain();
    apply_setting(0, 999, 0, 4095, 256, 66, 0);
    queue_random(115);
    drain();
    // thresholds crossed: every clean group hits both, zero point above full point
    apply_setting(999, 0, 4095, 0, 0, 0, 66);
    queue_random(115);
    drain();
    apply_setting(200, 700, 300, 3800, 511, 27, 27);
    queue_random(115);
    drain();
    apply_setting(500, 500, 40, 4050, 1, 0, 0);
    queue_random(115);
    drain();
    apply_setting(100, 1023, 800, 3000, 128, 66, 66);
    queue_random(115);
    drain();

    $display("run covered %0d sensor words and %0d readings over %0d register settings",
             words_sent, readings_checked, setting_no + 1);
    $display("readings: fresh %0d, held %0d, off %0d, short group %0d, pending %0d, faults %0d",
             status_seen[ST_FRESH], status_seen[ST_HELD_OPEN] + status_seen[ST_HELD_SHORT],
             status_seen[ST_OFF], status_seen[ST_FEW_SAMPLES],
             status_seen[ST_OPEN_NO_VALUE] + status_seen[ST_SHORT_NO_VALUE],
             status_seen[ST_OPEN_FAULT] + status_seen[ST_SHORT_FAULT]);
    if (mismatches == 0) begin
      $display("gas_sensor_sample_conditioner_core regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("gas_sensor_sample_conditioner_core regression: fail");
    end
    $finish;
  end

endmodule
